>>> rtl/core/ffba_pkg.sv
// ============================================================================
// ffba_pkg
// Shared types and constants of the first-fit block run allocator.
// ============================================================================
package ffba_pkg;

    // heap geometry
    localparam int NUM_BLOCKS   = 256;
    localparam int HEADER_BYTES = 8;
    localparam int IDX_W        = $clog2(NUM_BLOCKS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int PTR_W        = CNT_W + 1;

    // field widths
    localparam int BB_W     = 13;
    localparam int BIU_W    = 9;
    localparam int SIZE_W   = 16;
    localparam int RUN_W    = 9;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 1;

    // divider widths
    localparam int DIV_W     = SIZE_W + 1;
    localparam int STRIDE_W  = BB_W + 1;
    localparam int REM_W     = STRIDE_W + 1;
    localparam int NEED_W    = DIV_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'd1;

    // register reset values
    localparam logic [BB_W-1:0]  BLOCK_BYTES_RST   = 13'd64;
    localparam logic [BIU_W-1:0] BLOCKS_IN_USE_RST = 9'd256;

    // request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_BAD_INDEX = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIZE,
        S_SCAN,
        S_SKIP,
        S_FREE_LEN,
        S_FREE_CLR,
        S_RESULT
    } state_t;

endpackage

>>> rtl/core/first_fit_block_run_allocator.sv
// ============================================================================
// first_fit_block_run_allocator
// First-fit allocator of contiguous runs of equal heap blocks, with a
// shift-subtract divider for the run length and a scan of one free block per cycle.
// ============================================================================
//
//  channel   direction  handshake          payload
//  s_*       in         s_valid / s_ready  req_type, size_bytes, head_index
//  m_*       out        m_valid / m_ready  status, block_index, alloc_id,
//                                          run_blocks
//  cfg_*     in         cfg_wr_en only     cfg_wr_index, cfg_wr_data
//
// allocate: an accept step, plus a bit-serial divide and a size check when the
// size needs more than one block, then a scan that steps through each free
// block visited, reads and jumps over each used run and sees the heap end on
// a miss, then a result step.
// free: an accept step, a run-length read, a release step per released block
// and a finishing step, then a result step; an index beyond the heap goes from
// the accept step straight to the result step.
// the scan walker and the registered run-length read set these steps.
// reset clears all used bits at once; no clearing pass is needed.
// s_ready is high only when no item is in progress; a finished result waits
// in the result stage until the output register is free.
module first_fit_block_run_allocator (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input items
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [ffba_pkg::SIZE_W-1:0]    s_size_bytes,
    input  logic [7:0]                     s_head_index,
    // result items
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ffba_pkg::STATUS_W-1:0]  m_status,
    output logic [7:0]                     m_block_index,
    output logic [ffba_pkg::ID_W-1:0]      m_alloc_id,
    output logic [ffba_pkg::RUN_W-1:0]     m_run_blocks,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [ffba_pkg::CFG_W-1:0]     cfg_wr_data
);
    import ffba_pkg::*;

    // configuration registers
    logic [BB_W-1:0]      block_bytes_reg;
    logic [BIU_W-1:0]     blocks_in_use_reg;

    // derived configuration
    logic [BB_W-1:0]      bb_eff;
    logic [STRIDE_W-1:0]  stride;
    logic [CNT_W-1:0]     heap;

    // sequencer
    state_t               state_reg, state_next;
    logic [7:0]           head_reg, head_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [RUN_W-1:0]     need_reg, need_next;
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic [RUN_W-1:0]     cnt_reg, cnt_next;
    logic [RUN_W-1:0]     len_reg, len_next;
    logic [ID_W-1:0]      id_cnt_reg, id_cnt_next;

    // pending result
    status_t              res_status_reg, res_status_next;
    logic [7:0]           res_index_reg, res_index_next;
    logic [ID_W-1:0]      res_id_reg, res_id_next;
    logic [RUN_W-1:0]     res_run_reg, res_run_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    status_t              m_status_reg, m_status_next;
    logic [7:0]           m_index_reg, m_index_next;
    logic [ID_W-1:0]      m_id_reg, m_id_next;
    logic [RUN_W-1:0]     m_run_reg, m_run_next;

    // used bits, one per block
    logic [NUM_BLOCKS-1:0] used_reg;
    logic                  used_wr_en;
    logic [IDX_W-1:0]      used_wr_idx;
    logic                  used_wr_val;

    // run-length memory
    logic [RUN_W-1:0]     run_mem [NUM_BLOCKS];
    logic [RUN_W-1:0]     rd_data_reg;
    logic                 mem_wr_en;
    logic [IDX_W-1:0]     mem_wr_addr;
    logic [RUN_W-1:0]     mem_wr_data;
    logic                 mem_rd_en;
    logic [IDX_W-1:0]     mem_rd_addr;

    // shared datapath temporaries
    logic [REM_W-1:0]     div_shift;
    logic                 div_bit;
    logic [NEED_W-1:0]    need_full;
    logic [PTR_W-1:0]     clr_addr;
    logic [RUN_W-1:0]     skip;

    // block size of zero acts as one
    assign bb_eff = (block_bytes_reg == '0) ? BB_W'(1) : block_bytes_reg;
    assign stride = STRIDE_W'(bb_eff) + STRIDE_W'(HEADER_BYTES);
    assign heap   = (CNT_W'(blocks_in_use_reg) > CNT_W'(NUM_BLOCKS)) ?
                    CNT_W'(NUM_BLOCKS) : CNT_W'(blocks_in_use_reg);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_bytes_reg   <= BLOCK_BYTES_RST;
            blocks_in_use_reg <= BLOCKS_IN_USE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_BLOCK_BYTES:   block_bytes_reg   <= cfg_wr_data[BB_W-1:0];
                REG_BLOCKS_IN_USE: blocks_in_use_reg <= cfg_wr_data[BIU_W-1:0];
                default: ;
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            id_cnt_reg  <= '0;
            m_valid_reg <= 1'b0;
            used_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            id_cnt_reg  <= id_cnt_next;
            m_valid_reg <= m_valid_next;
            if (used_wr_en) begin
                used_reg[used_wr_idx] <= used_wr_val;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        head_reg       <= head_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        div_cnt_reg    <= div_cnt_next;
        need_reg       <= need_next;
        ptr_reg        <= ptr_next;
        cnt_reg        <= cnt_next;
        len_reg        <= len_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_id_reg     <= res_id_next;
        res_run_reg    <= res_run_next;
        m_status_reg   <= m_status_next;
        m_index_reg    <= m_index_next;
        m_id_reg       <= m_id_next;
        m_run_reg      <= m_run_next;
    end

    // run-length memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            run_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            rd_data_reg <= run_mem[mem_rd_addr];
        end
    end

    // divider step and scan helpers
    assign div_shift = {rem_reg[REM_W-2:0], quo_reg[DIV_W-1]};
    assign div_bit   = (div_shift >= REM_W'(stride));
    assign need_full = NEED_W'(quo_reg) + NEED_W'(1);
    assign clr_addr  = PTR_W'(head_reg) + PTR_W'(cnt_reg);
    assign skip      = (rd_data_reg == '0) ? RUN_W'(1) : rd_data_reg;

    // sequencer
    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        div_cnt_next    = div_cnt_reg;
        need_next       = need_reg;
        ptr_next        = ptr_reg;
        cnt_next        = cnt_reg;
        len_next        = len_reg;
        id_cnt_next     = id_cnt_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_id_next     = res_id_reg;
        res_run_next    = res_run_reg;
        m_status_next   = m_status_reg;
        m_index_next    = m_index_reg;
        m_id_next       = m_id_reg;
        m_run_next      = m_run_reg;
        used_wr_en      = 1'b0;
        used_wr_idx     = ptr_reg[IDX_W-1:0];
        used_wr_val     = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = ptr_reg[IDX_W-1:0];
        mem_wr_data     = need_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = ptr_reg[IDX_W-1:0];
        s_ready         = 1'b0;

        // output register drains on handshake
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    head_next = s_head_index;
                    ptr_next  = '0;
                    cnt_next  = '0;
                    if (s_req_type == REQ_FREE) begin
                        if (CNT_W'(s_head_index) >= heap) begin
                            res_status_next = ST_BAD_INDEX;
                            res_index_next  = s_head_index;
                            res_id_next     = '0;
                            res_run_next    = '0;
                            state_next      = S_RESULT;
                        end else begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = s_head_index[IDX_W-1:0];
                            state_next  = S_FREE_LEN;
                        end
                    end else if (s_size_bytes <= SIZE_W'(bb_eff)) begin
                        need_next  = RUN_W'(1);
                        state_next = S_SCAN;
                    end else begin
                        // ceil((size - bb) / stride) is floor((size + header - 1) / stride)
                        quo_next     = DIV_W'(s_size_bytes) + DIV_W'(HEADER_BYTES)
                                       - DIV_W'(1);
                        rem_next     = '0;
                        div_cnt_next = '0;
                        state_next   = S_DIV;
                    end
                end
            end

            // one quotient bit per cycle
            S_DIV: begin
                rem_next     = div_bit ? (div_shift - REM_W'(stride)) : div_shift;
                quo_next     = {quo_reg[DIV_W-2:0], div_bit};
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                    state_next = S_SIZE;
                end
            end

            // a run longer than the heap can never fit
            S_SIZE: begin
                if (need_full > NEED_W'(heap)) begin
                    res_status_next = ST_NO_SPACE;
                    res_index_next  = '0;
                    res_id_next     = '0;
                    res_run_next    = '0;
                    state_next      = S_RESULT;
                end else begin
                    need_next  = need_full[RUN_W-1:0];
                    state_next = S_SCAN;
                end
            end

            // first-fit walk, one free block per cycle; a used run is jumped over in S_SKIP
            S_SCAN: begin
                if (ptr_reg >= PTR_W'(heap)) begin
                    res_status_next = ST_NO_SPACE;
                    res_index_next  = '0;
                    res_id_next     = '0;
                    res_run_next    = '0;
                    state_next      = S_RESULT;
                end else if (used_reg[ptr_reg[IDX_W-1:0]]) begin
                    mem_rd_en  = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SKIP;
                end else if (cnt_reg + RUN_W'(1) == need_reg) begin
                    // run found: mark its head
                    used_wr_en      = 1'b1;
                    used_wr_idx     = IDX_W'(ptr_reg - PTR_W'(cnt_reg));
                    used_wr_val     = 1'b1;
                    mem_wr_en       = 1'b1;
                    mem_wr_addr     = IDX_W'(ptr_reg - PTR_W'(cnt_reg));
                    mem_wr_data     = need_reg;
                    id_cnt_next     = id_cnt_reg + ID_W'(1);
                    res_status_next = ST_OK;
                    res_index_next  = 8'(ptr_reg - PTR_W'(cnt_reg));
                    res_id_next     = id_cnt_reg + ID_W'(1);
                    res_run_next    = need_reg;
                    state_next      = S_RESULT;
                end else begin
                    cnt_next = cnt_reg + RUN_W'(1);
                    ptr_next = ptr_reg + PTR_W'(1);
                end
            end

            // jump over a whole used run
            S_SKIP: begin
                ptr_next   = ptr_reg + PTR_W'(skip);
                state_next = S_SCAN;
            end

            // run length of a non-head reads as zero
            S_FREE_LEN: begin
                len_next   = used_reg[head_reg[IDX_W-1:0]] ? rd_data_reg : '0;
                cnt_next   = '0;
                state_next = S_FREE_CLR;
            end

            // release one block per cycle, stopping at the end of the heap
            S_FREE_CLR: begin
                if ((cnt_reg < len_reg) && (clr_addr < PTR_W'(heap))) begin
                    used_wr_en  = 1'b1;
                    used_wr_idx = clr_addr[IDX_W-1:0];
                    used_wr_val = 1'b0;
                    cnt_next    = cnt_reg + RUN_W'(1);
                end else begin
                    res_status_next = ST_OK;
                    res_index_next  = head_reg;
                    res_id_next     = '0;
                    res_run_next    = len_reg;
                    state_next      = S_RESULT;
                end
            end

            // hand the result to the output register once it is free
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_index_next  = res_index_reg;
                    m_id_next     = res_id_reg;
                    m_run_next    = res_run_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_block_index = m_index_reg;
    assign m_alloc_id    = m_id_reg;
    assign m_run_blocks  = m_run_reg;

endmodule

>>> rtl/core/ffba_checker.sv
// ============================================================================
// ffba_checker
// Port-level checks of the block run allocator, bound to its top level.
// ============================================================================
module ffba_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [ffba_pkg::STATUS_W-1:0] m_status,
    input logic [7:0]                    m_block_index,
    input logic [ffba_pkg::ID_W-1:0]     m_alloc_id,
    input logic [ffba_pkg::RUN_W-1:0]    m_run_blocks
);
    import ffba_pkg::*;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
        $stable(m_block_index) && $stable(m_alloc_id) && $stable(m_run_blocks))
        else $error("result item changed while stalled");

    // one item at a time: busy right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an accept");

    // failures carry no id and no blocks
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> (m_alloc_id == '0) && (m_run_blocks == '0))
        else $error("failed item carries id or blocks");

    // no-space result points at block zero
    a_nospace_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_NO_SPACE) |-> (m_block_index == '0))
        else $error("no-space item with nonzero index");

endmodule

bind first_fit_block_run_allocator ffba_checker u_ffba_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_block_index (m_block_index),
    .m_alloc_id    (m_alloc_id),
    .m_run_blocks  (m_run_blocks)
);
